// File: hdl/sccc_pkg.sv
// Shared types, constants and functions for the scratchpad CRC check and
// temperature convert unit. No dependencies.
package sccc_pkg;

    // Frame length in bytes; position value of FRAME_LEN means idle
    localparam logic [3:0] FRAME_LEN      = 4'd9;
    localparam logic [3:0] POS_TEMP_LOW   = 4'd0;
    localparam logic [3:0] POS_TEMP_HIGH  = 4'd1;
    localparam logic [3:0] POS_CONFIG     = 4'd4;
    localparam logic [3:0] POS_LAST       = 4'd8;

    // Reflected form of x^8+x^5+x^4+1
    localparam logic [7:0] CRC_POLY       = 8'h8C;

    // Resolution codes
    localparam logic [1:0] RES_9BIT       = 2'd0;
    localparam logic [1:0] RES_10BIT      = 2'd1;
    localparam logic [1:0] RES_11BIT      = 2'd2;
    localparam logic [1:0] RES_12BIT      = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic               crc_ok;
        logic signed [15:0] temperature_tenths;
        logic [1:0]         resolution_code;
        logic [7:0]         crc_remainder;
    } out_word_t;

    // One byte of CRC-8, LSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                            input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[0];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

    // Mask that clears the undefined low bits for each resolution
    function automatic logic [15:0] res_mask(input logic [1:0] code);
        logic [15:0] m;
        unique case (code)
            RES_9BIT:  m = 16'hFFF8;
            RES_10BIT: m = 16'hFFFC;
            RES_11BIT: m = 16'hFFFE;
            RES_12BIT: m = 16'hFFFF;
            default:   m = 16'hFFFF;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/scratchpad_crc_check_temp_convert_unit.sv
// Scratchpad CRC check and temperature convert unit, top level; uses sccc_pkg.
// Input register then result register; the ninth byte's result word is
// written to the result register. Throughput: one word per cycle unless
// m_ready stalls a held result; the CRC byte update and the decode run in one
// pass from the input register to the result register.
// Reset (aresetn, synchronous, active low) empties both registers, clears the
// CRC and leaves the frame position idle until a start word.
module scratchpad_crc_check_temp_convert_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sccc_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output sccc_pkg::out_word_t m_word
);

    // Input register
    logic               in_valid_reg;
    sccc_pkg::in_word_t in_word_reg;

    // Frame state
    logic [7:0] crc_reg,       crc_next;
    logic [3:0] pos_reg,       pos_next;
    logic [7:0] temp_low_reg,  temp_low_next;
    logic [7:0] temp_high_reg, temp_high_next;
    logic [1:0] res_reg,       res_next;

    // Result register
    logic                m_valid_reg, m_valid_next;
    sccc_pkg::out_word_t m_word_reg,  m_word_next;

    logic               advance;
    logic               take;
    logic [3:0]         pos_eff;
    logic [7:0]         crc_base;
    logic [7:0]         crc_new;
    logic               emit;
    logic [15:0]        raw;
    logic signed [18:0] prod;
    logic signed [18:0] biased;
    logic signed [18:0] quot;

    // Move the held word on when the result side can take it
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Frame tracking and CRC update
    always_comb begin
        take     = in_word_reg.frame_start || (pos_reg < sccc_pkg::FRAME_LEN);
        pos_eff  = in_word_reg.frame_start ? sccc_pkg::POS_TEMP_LOW : pos_reg;
        crc_base = in_word_reg.frame_start ? 8'h00 : crc_reg;
        crc_new  = sccc_pkg::crc_byte(crc_base, in_word_reg.data_byte);
        emit     = take && (pos_eff == sccc_pkg::POS_LAST);

        crc_next       = crc_reg;
        pos_next       = pos_reg;
        temp_low_next  = temp_low_reg;
        temp_high_next = temp_high_reg;
        res_next       = res_reg;
        if (advance && take) begin
            crc_next = crc_new;
            pos_next = pos_eff + 4'd1;
            if (pos_eff == sccc_pkg::POS_TEMP_LOW) begin
                temp_low_next = in_word_reg.data_byte;
            end
            if (pos_eff == sccc_pkg::POS_TEMP_HIGH) begin
                temp_high_next = in_word_reg.data_byte;
            end
            if (pos_eff == sccc_pkg::POS_CONFIG) begin
                res_next = in_word_reg.data_byte[6:5];
            end
        end
    end

    // Decode: mask, times 5, divide by 8 toward zero
    always_comb begin
        raw    = {temp_high_reg, temp_low_reg} & sccc_pkg::res_mask(res_reg);
        prod   = (19'(signed'(raw)) <<< 2) + 19'(signed'(raw));
        biased = prod[18] ? (prod + 19'sd7) : prod;
        quot   = biased >>> 3;
    end

    // Result register next value
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance && emit) begin
            m_valid_next                   = 1'b1;
            m_word_next.crc_ok             = (crc_new == 8'h00);
            m_word_next.temperature_tenths = quot[15:0];
            m_word_next.resolution_code    = res_reg;
            m_word_next.crc_remainder      = crc_new;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            crc_reg      <= 8'h00;
            pos_reg      <= sccc_pkg::FRAME_LEN;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg <= m_valid_next;
            crc_reg     <= crc_next;
            pos_reg     <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_word;
        end
        temp_low_reg  <= temp_low_next;
        temp_high_reg <= temp_high_next;
        res_reg       <= res_next;
        m_word_reg    <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// File: hdl/sccc_checker.sv
// Port-level checks for the scratchpad CRC check and temperature convert unit,
// bound to the top level. Depends on sccc_pkg.
module sccc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sccc_pkg::out_word_t m_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Verdict agrees with remainder
    a_crc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.crc_ok == (m_word.crc_remainder == 8'h00)))
        else $error("crc_ok disagrees with crc_remainder");

    // Reading stays within the scaled 16-bit range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.temperature_tenths >= -16'sd20480) &&
                    (m_word.temperature_tenths <= 16'sd20479))
        else $error("temperature_tenths out of range");

    // A fresh result follows an accepted input word
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without an accepted input word");

    // Drop results in reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind scratchpad_crc_check_temp_convert_unit sccc_checker u_sccc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
